// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("assertion failed");

// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/dptf_pkg.sv =====
`default_nettype none

package dptf_pkg;

  // Command codes carried on the kind field.
  typedef enum logic [1:0] {
    KIND_PULSE   = 2'd0,
    KIND_CONSUME = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_SET_EN  = 2'd3
  } kind_t;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned SCALE_W = 10;
  // The lockout window is held in microseconds: milliseconds times 1000.
  localparam int unsigned LIMIT_W = MS_W + SCALE_W;

  localparam logic [SCALE_W-1:0] DEBOUNCE_SCALE = 10'd1000;
  localparam logic [LIMIT_W-1:0] RESET_LIMIT    = 26'd50000;

  // One result beat as handed from the control stage to the ports.
  typedef struct packed {
    logic              strobe;
    logic              pulse_valid;
    logic [TIME_W-1:0] dropped_count;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/debounced_pulse_timestamp_fifo_core.sv =====
`default_nettype none
// Channel   Handshake                       Payload
// input     start high, busy low            in_kind, in_now_us, in_enable_value
// result    out_strobe for one cycle        out_pulse_valid, out_timestamp_us,
//                                           out_dropped_count
// config    cfg_we                          cfg_wdata (debounce in ms)
//
// Every command gives one result beat once it is taken and has passed the
// input register and then the control stage, whose result register and
// the registered queue read line up. busy stays low, so a command can be
// taken in every cycle. The receiver cannot stall. rst_n is synchronous and
// empties the queue at once; queue storage is not cleared.

module debounced_pulse_timestamp_fifo_core #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [dptf_pkg::TIME_W-1:0]  in_now_us,
  input  wire logic                         in_enable_value,
  output logic                              out_strobe,
  output logic                              out_pulse_valid,
  output logic [dptf_pkg::TIME_W-1:0]       out_timestamp_us,
  output logic [dptf_pkg::TIME_W-1:0]       out_dropped_count,
  input  wire logic                         cfg_we,
  input  wire logic [dptf_pkg::MS_W-1:0]    cfg_wdata
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  logic                           in_vld_r;
  dptf_pkg::kind_t                in_kind_r;
  logic [dptf_pkg::TIME_W-1:0]    in_now_r;
  logic                           in_en_r;
  logic [dptf_pkg::LIMIT_W-1:0]   limit_r, limit_nxt;
  logic                           ram_we;
  logic                           ram_re;
  logic [PW-1:0]                  ram_waddr;
  logic [PW-1:0]                  ram_raddr;
  logic [dptf_pkg::TIME_W-1:0]    ram_rdata;
  dptf_pkg::res_t                 res;

  assign busy = 1'b0;

  // Input register: every command beat lands here first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_kind_r <= dptf_pkg::kind_t'(in_kind);
    in_now_r  <= in_now_us;
    in_en_r   <= in_enable_value;
  end

  function automatic logic [dptf_pkg::LIMIT_W-1:0] LIMIT_W_MUL(
    input logic [dptf_pkg::MS_W-1:0] ms
  );
    LIMIT_W_MUL = {{dptf_pkg::SCALE_W{1'b0}}, ms} *
                  {{dptf_pkg::MS_W{1'b0}}, dptf_pkg::DEBOUNCE_SCALE};
  endfunction

  // The debounce setting is kept already scaled to microseconds.
  assign limit_nxt = cfg_we
    ? LIMIT_W_MUL(cfg_wdata)
    : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= dptf_pkg::RESET_LIMIT;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  dptf_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_vld    (in_vld_r),
    .item_kind   (in_kind_r),
    .item_now_us (in_now_r),
    .item_enable (in_en_r),
    .limit_us    (limit_r),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .res         (res)
  );

  dptf_ram #(
    .WIDTH (dptf_pkg::TIME_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_now_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result beat: the popped time shows only with a valid pop.
  assign out_strobe        = res.strobe;
  assign out_pulse_valid   = res.pulse_valid;
  assign out_dropped_count = res.dropped_count;
  assign out_timestamp_us  = res.pulse_valid ? ram_rdata : '0;

endmodule

`default_nettype wire

// ===== hdl/dptf_ram.sv =====
`default_nettype none

module dptf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dptf_ctrl.sv =====
`default_nettype none

module dptf_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              item_vld,
  input  wire dptf_pkg::kind_t                   item_kind,
  input  wire logic [dptf_pkg::TIME_W-1:0]       item_now_us,
  input  wire logic                              item_enable,
  input  wire logic [dptf_pkg::LIMIT_W-1:0]      limit_us,
  output logic                                   ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]         ram_waddr,
  output logic                                   ram_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0]         ram_raddr,
  output dptf_pkg::res_t                         res
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  logic [PW-1:0]                 wp_r, wp_nxt;
  logic [PW-1:0]                 rp_r, rp_nxt;
  logic [dptf_pkg::TIME_W-1:0]   last_r, last_nxt;
  logic [dptf_pkg::TIME_W-1:0]   drop_r, drop_nxt;
  logic                          en_r, en_nxt;
  dptf_pkg::res_t                res_r, res_nxt;
  logic [dptf_pkg::TIME_W-1:0]   diff;
  logic                          locked;
  logic [PW-1:0]                 wp_adv;
  logic [PW-1:0]                 rp_adv;

  // Ring pointers wrap at the queue depth, which need not be a power of two.
  assign wp_adv = (wp_r == LAST_SLOT) ? '0 : wp_r + 1'b1;
  assign rp_adv = (rp_r == LAST_SLOT) ? '0 : rp_r + 1'b1;

  // A last accepted time of zero means no pulse is on record.
  assign diff   = item_now_us - last_r;
  assign locked = (last_r != '0) &&
                  (diff < {{(dptf_pkg::TIME_W - dptf_pkg::LIMIT_W){1'b0}}, limit_us});

  assign ram_waddr = wp_r;
  assign ram_raddr = rp_r;

  // Decode the registered command and work out the next queue state.
  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    last_nxt = last_r;
    drop_nxt = drop_r;
    en_nxt   = en_r;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    res_nxt.pulse_valid = 1'b0;
    if (item_vld) begin
      unique case (item_kind)
        dptf_pkg::KIND_PULSE: begin
          if (en_r && !locked) begin
            last_nxt = item_now_us;
            if (wp_adv == rp_r) begin
              drop_nxt = drop_r + 1'b1;
            end else begin
              ram_we = 1'b1;
              wp_nxt = wp_adv;
            end
          end
        end
        dptf_pkg::KIND_CONSUME: begin
          if (rp_r != wp_r) begin
            ram_re = 1'b1;
            rp_nxt = rp_adv;
            res_nxt.pulse_valid = 1'b1;
          end
        end
        dptf_pkg::KIND_CLEAR: begin
          wp_nxt   = '0;
          rp_nxt   = '0;
          last_nxt = '0;
        end
        dptf_pkg::KIND_SET_EN: begin
          en_nxt   = item_enable;
          wp_nxt   = '0;
          rp_nxt   = '0;
          last_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    res_nxt.strobe        = item_vld;
    res_nxt.dropped_count = drop_nxt;
  end

  // Queue state and the result beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      last_r <= '0;
      drop_r <= '0;
      en_r   <= 1'b1;
      res_r  <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      last_r <= last_nxt;
      drop_r <= drop_nxt;
      en_r   <= en_nxt;
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== hdl/dptf_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module dptf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_strobe,
  input wire logic        out_pulse_valid,
  input wire logic [31:0] out_timestamp_us,
  input wire logic [31:0] out_dropped_count
);

  // Every taken command gives its result beat after the input and result registers.
  `ASSERT_IMPLIES(a_beat_follows, clk, rst_n, start && !busy, ##2 out_strobe)

  // No result beat appears without a taken command ahead of it through those registers.
  `ASSERT_IMPLIES(a_no_spurious_beat, clk, rst_n, out_strobe, $past(start && !busy, 2))

  // A popped time is reported only on a beat, and a miss reads as zero.
  `ASSERT_ALWAYS(a_valid_on_beat, clk, rst_n,
    (!out_pulse_valid || out_strobe) && (out_pulse_valid || out_timestamp_us == 32'd0))

  // Back to back beats see the drop count hold or step by one.
  `ASSERT_IMPLIES(a_drop_steps, clk, rst_n, out_strobe && $past(out_strobe),
    out_dropped_count == $past(out_dropped_count) ||
    out_dropped_count == $past(out_dropped_count) + 32'd1)

endmodule

bind debounced_pulse_timestamp_fifo_core dptf_checker u_dptf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_pulse_valid   (out_pulse_valid),
  .out_timestamp_us  (out_timestamp_us),
  .out_dropped_count (out_dropped_count)
);

`default_nettype wire
